FILE: rtl/ttq_pkg.sv
// shared types and constants for the threshold trigger qualifier
`default_nettype none
package ttq_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [31:0] HOUR_MS = 32'd3600000;

  typedef enum logic [2:0] {
    OC_FIRED      = 3'd0,
    OC_DISABLED   = 3'd1,
    OC_COOLDOWN   = 3'd2,
    OC_RATE_LIMIT = 3'd3,
    OC_NO_MATCH   = 3'd4,
    OC_FALSE      = 3'd5,
    OC_SUSTAINING = 3'd6
  } outcome_t;

  typedef enum logic [2:0] {
    REG_RULE_ENABLED    = 3'd0,
    REG_COMPARE_OP      = 3'd1,
    REG_THRESHOLD_LOW   = 3'd2,
    REG_THRESHOLD_UPPER = 3'd3,
    REG_SUSTAIN_MS      = 3'd4,
    REG_COOLDOWN_SPAN   = 3'd5,
    REG_MAX_PER_HOUR    = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    CMP_GT        = 3'd0,
    CMP_LT        = 3'd1,
    CMP_GE        = 3'd2,
    CMP_LE        = 3'd3,
    CMP_EQ        = 3'd4,
    CMP_NE        = 3'd5,
    CMP_IN_RANGE  = 3'd6,
    CMP_OUT_RANGE = 3'd7
  } cmp_mode_t;

  // values compare as raw signed words, the fraction point does not matter
  typedef struct packed {
    logic               rule_enabled;
    logic [3:0]         compare_op;
    logic signed [31:0] threshold_low;
    logic signed [31:0] threshold_upper;
    logic [31:0]        sustain_ms;
    logic [31:0]        cooldown_span;
    logic [15:0]        max_per_hour;
  } cfg_t;

  // classified item between front and back
  typedef struct packed {
    logic [31:0] now_ms;
    logic        trigger_match;
    logic        cond;
  } item_t;

  typedef struct packed {
    logic        fired;
    outcome_t    outcome;
    logic [31:0] total_firings;
    logic [15:0] hour_firings;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/ttq_front.sv
// front stage: takes input items and evaluates the threshold condition
`default_nettype none
module ttq_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ttq_pkg::cfg_t      cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [31:0]        now_ms,
  input  wire logic               trigger_match,
  input  wire logic               sample_valid,
  input  wire logic signed [31:0] sample_value,
  output logic                    item_valid,
  input  wire logic               item_ready,
  output ttq_pkg::item_t          item
);

  logic cmp_raw;
  logic cond;

  always_comb begin
    case (ttq_pkg::cmp_mode_t'(cfg.compare_op[2:0]))
      ttq_pkg::CMP_GT:       cmp_raw = sample_value >  cfg.threshold_low;
      ttq_pkg::CMP_LT:       cmp_raw = sample_value <  cfg.threshold_low;
      ttq_pkg::CMP_GE:       cmp_raw = sample_value >= cfg.threshold_low;
      ttq_pkg::CMP_LE:       cmp_raw = sample_value <= cfg.threshold_low;
      ttq_pkg::CMP_EQ:       cmp_raw = sample_value == cfg.threshold_low;
      ttq_pkg::CMP_NE:       cmp_raw = sample_value != cfg.threshold_low;
      ttq_pkg::CMP_IN_RANGE: cmp_raw = (sample_value >= cfg.threshold_low) &&
                                       (sample_value <= cfg.threshold_upper);
      default:               cmp_raw = (sample_value <  cfg.threshold_low) ||
                                       (sample_value >  cfg.threshold_upper);
    endcase
    // invalid sample is false even under negation
    cond = sample_valid && (cmp_raw ^ cfg.compare_op[3]);
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.now_ms        <= now_ms;
      item.trigger_match <= trigger_match;
      item.cond          <= cond;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ttq_queue.sv
// small fifo of classified items between front and back
`default_nettype none
module ttq_queue #(
  parameter int unsigned DEPTH = ttq_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire ttq_pkg::item_t push_item,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output ttq_pkg::item_t      pop_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  ttq_pkg::item_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign push_ready = count != FULL;
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ttq_back.sv
// back stage: cooldown, hourly limit, sustain timing and firing counters
`default_nettype none
module ttq_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ttq_pkg::cfg_t    cfg,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire ttq_pkg::item_t   item,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output ttq_pkg::result_t      res
);

  logic        cooling;
  logic [31:0] last_fire_time;
  logic [31:0] window_start_time;
  logic [15:0] window_count;
  logic [31:0] sustain_start_time;
  logic [31:0] fire_count;

  logic        cooling_next;
  logic [31:0] last_fire_time_next;
  logic [31:0] window_start_time_next;
  logic [15:0] window_count_next;
  logic [31:0] sustain_start_time_next;
  logic [31:0] fire_count_next;
  ttq_pkg::outcome_t outcome_next;

  logic [31:0] since_fire;
  logic [31:0] since_window;
  logic [31:0] since_sustain;
  logic        limit_on;
  logic        roll;
  logic [15:0] wc;
  logic [31:0] ws;
  logic        pop;

  assign item_ready = !res_valid || res_ready;
  assign pop        = item_valid && item_ready;

  assign since_fire    = item.now_ms - last_fire_time;
  assign since_window  = item.now_ms - window_start_time;
  assign since_sustain = item.now_ms - sustain_start_time;
  assign limit_on      = cfg.max_per_hour != '0;
  assign roll          = limit_on && (since_window >= ttq_pkg::HOUR_MS);
  assign wc            = roll ? 16'd0 : window_count;
  assign ws            = roll ? item.now_ms : window_start_time;

  always_comb begin
    cooling_next            = cooling;
    last_fire_time_next     = last_fire_time;
    window_start_time_next  = window_start_time;
    window_count_next       = window_count;
    sustain_start_time_next = sustain_start_time;
    fire_count_next         = fire_count;
    outcome_next            = ttq_pkg::OC_DISABLED;
    if (!cfg.rule_enabled) begin
      outcome_next = ttq_pkg::OC_DISABLED;
    end else if (cooling && (since_fire < cfg.cooldown_span)) begin
      outcome_next = ttq_pkg::OC_COOLDOWN;
    end else begin
      cooling_next           = 1'b0;
      window_start_time_next = ws;
      window_count_next      = wc;
      if (limit_on && (wc >= cfg.max_per_hour)) begin
        outcome_next = ttq_pkg::OC_RATE_LIMIT;
      end else if (!item.trigger_match) begin
        outcome_next = ttq_pkg::OC_NO_MATCH;
      end else if (!item.cond) begin
        sustain_start_time_next = '0;
        outcome_next            = ttq_pkg::OC_FALSE;
      end else if ((cfg.sustain_ms != '0) && (sustain_start_time == '0)) begin
        // a start at time zero stores zero, so the next true item restarts it
        sustain_start_time_next = item.now_ms;
        outcome_next            = ttq_pkg::OC_SUSTAINING;
      end else if ((cfg.sustain_ms != '0) && (since_sustain < cfg.sustain_ms)) begin
        outcome_next = ttq_pkg::OC_SUSTAINING;
      end else begin
        // the sustain start is left alone when no sustain time is set
        if (cfg.sustain_ms != '0) begin
          sustain_start_time_next = '0;
        end
        last_fire_time_next     = item.now_ms;
        fire_count_next         = fire_count + 32'd1;
        window_count_next       = (wc == 16'hffff) ? wc : wc + 16'd1;
        cooling_next            = cfg.cooldown_span != '0;
        outcome_next            = ttq_pkg::OC_FIRED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cooling            <= 1'b0;
      last_fire_time     <= '0;
      window_start_time  <= '0;
      window_count       <= '0;
      sustain_start_time <= '0;
      fire_count         <= '0;
      res_valid          <= 1'b0;
    end else begin
      if (pop) begin
        cooling            <= cooling_next;
        last_fire_time     <= last_fire_time_next;
        window_start_time  <= window_start_time_next;
        window_count       <= window_count_next;
        sustain_start_time <= sustain_start_time_next;
        fire_count         <= fire_count_next;
      end
      if (item_ready) begin
        res_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.fired         <= outcome_next == ttq_pkg::OC_FIRED;
      res.outcome       <= outcome_next;
      res.total_firings <= fire_count_next;
      res.hour_firings  <= window_count_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/threshold_trigger_qualifier_core.sv
// top level of the threshold trigger qualifier
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in       | in_valid/in_ready    | now_ms, trigger_match, sample_valid, sample_value
//   out      | out_valid/out_ready  | fired, outcome, total_firings, hour_firings
//
// one item per cycle sustained while the output is not stalled; an item's result passes
// through the front register, the queue and the result register before it is presented.
// the back stage updates all rule state as it takes each item, which sets that rate.
// rst clears the configuration, the counters and all valid flags.
// a stalled output fills the result register, then the queue, then the front
// register before in_ready drops; cfg_ready is always high.
`default_nettype none
module threshold_trigger_qualifier_core #(
  parameter int unsigned QUEUE_DEPTH = ttq_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [31:0]        now_ms,
  input  wire logic               trigger_match,
  input  wire logic               sample_valid,
  input  wire logic signed [31:0] sample_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    fired,
  output logic [2:0]              outcome,
  output logic [31:0]             total_firings,
  output logic [15:0]             hour_firings
);

  ttq_pkg::cfg_t    cfg;
  ttq_pkg::item_t   front_item;
  ttq_pkg::item_t   queue_item;
  ttq_pkg::result_t res;
  logic             front_valid;
  logic             front_ready;
  logic             queue_valid;
  logic             queue_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (ttq_pkg::reg_index_t'(cfg_index))
        ttq_pkg::REG_RULE_ENABLED:    cfg.rule_enabled    <= cfg_data[0];
        ttq_pkg::REG_COMPARE_OP:      cfg.compare_op      <= cfg_data[3:0];
        ttq_pkg::REG_THRESHOLD_LOW:   cfg.threshold_low   <= $signed(cfg_data);
        ttq_pkg::REG_THRESHOLD_UPPER: cfg.threshold_upper <= $signed(cfg_data);
        ttq_pkg::REG_SUSTAIN_MS:      cfg.sustain_ms      <= cfg_data;
        ttq_pkg::REG_COOLDOWN_SPAN:   cfg.cooldown_span   <= cfg_data;
        ttq_pkg::REG_MAX_PER_HOUR:    cfg.max_per_hour    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ttq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .now_ms        (now_ms),
    .trigger_match (trigger_match),
    .sample_valid  (sample_valid),
    .sample_value  (sample_value),
    .item_valid    (front_valid),
    .item_ready    (front_ready),
    .item          (front_item)
  );

  ttq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  ttq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign fired         = res.fired;
  assign outcome       = res.outcome;
  assign total_firings = res.total_firings;
  assign hour_firings  = res.hour_firings;

  // fired flag agrees with the outcome code
  a_fired_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fired == (outcome == ttq_pkg::OC_FIRED)))
    else $error("fired flag disagrees with outcome");

  // a front item held back by a full queue keeps its contents
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (front_valid && !front_ready) |=> (front_valid && $stable(front_item)))
    else $error("front item lost while queue full");

  // disabled rule reported only while the rule is off
  a_disabled_cfg: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome == ttq_pkg::OC_DISABLED)) |-> !cfg.rule_enabled)
    else $error("disabled outcome with rule enabled");

  // a firing result counts at least one firing in the hour while an hourly limit is set
  a_fire_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fired) |-> (hour_firings != 16'd0 || cfg.max_per_hour == 16'd0))
    else $error("firing not counted in hour window");

endmodule
`default_nettype wire
